>>> rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, codes, constants and helpers for the parameter frame codec.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ID_W    = 6;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned FRAME_W = 56;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [FRAME_W-1:0] t_frame;

    typedef enum logic [1:0] {
        ACT_ENCODE = 2'd0,
        ACT_DECODE = 2'd1,
        ACT_SEED   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // Fillers for unused upper value bytes 3, 4 and 5
    localparam t_byte FILL_B3 = 8'h69;
    localparam t_byte FILL_B4 = 8'h96;
    localparam t_byte FILL_B5 = 8'h99;

    // Decoded type byte codes
    localparam t_byte TYPE_4B = 8'hAA;
    localparam t_byte TYPE_3B = 8'hA5;
    localparam t_byte TYPE_2B = 8'h5A;
    localparam t_byte TYPE_1B = 8'h55;

    typedef struct packed {
        t_action              action;
        logic [ID_W-1:0]      entry_id;
        logic [VALUE_W-1:0]   param_value;
        t_frame               rx_frame;
    } t_in_item;

    typedef struct packed {
        t_byte                key;
        logic [VALUE_W-1:0]   value;
        logic                 ok;
    } t_dec_result;

    // Key scramble for frame byte 0: out bits 0..7 take key bits 5,3,7,1,6,0,4,2
    function automatic t_byte permute_key(input t_byte k);
        permute_key = {k[2], k[4], k[0], k[6], k[1], k[7], k[3], k[5]};
    endfunction

endpackage

>>> rtl/pfc_if.sv
// ----------------------------------------------------------------------------
// pfc_in_if / pfc_out_if
// Valid/ready channels carrying codec requests and codec results.
// ----------------------------------------------------------------------------
interface pfc_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic [5:0]                 entry_id;
    logic [31:0]                param_value;
    logic [55:0]                rx_frame;

    modport source (output valid, action, entry_id, param_value, rx_frame, input ready);
    modport sink   (input valid, action, entry_id, param_value, rx_frame, output ready);
endinterface

interface pfc_out_if;
    logic                       valid;
    logic                       ready;
    logic [55:0]                tx_frame;
    logic [31:0]                read_value;
    logic                       read_ok;

    modport source (output valid, tx_frame, read_value, read_ok, input ready);
    modport sink   (input valid, tx_frame, read_value, read_ok, output ready);
endinterface

>>> rtl/pfc_encode.sv
// ----------------------------------------------------------------------------
// pfc_encode
// Builds a scrambled 7-byte frame from an id and a value under the key.
// ----------------------------------------------------------------------------
module pfc_encode
    import pfc_pkg::*;
(
    input  t_byte                i_key,
    input  logic [ID_W-1:0]      i_entry_id,
    input  logic [VALUE_W-1:0]   i_param_value,
    output t_frame               o_tx_frame
);

    t_byte      raw3, raw4, raw5, raw6;
    logic       zero3, zero4, zero5;
    logic [1:0] used_cnt;
    t_byte      b0, b1, b2, b3, b4, b5, b6;

    assign raw3  = i_param_value[31:24];
    assign raw4  = i_param_value[23:16];
    assign raw5  = i_param_value[15:8];
    assign raw6  = i_param_value[7:0];
    assign zero3 = (raw3 == '0);
    assign zero4 = (raw4 == '0);
    assign zero5 = (raw5 == '0);

    // Count of used bytes beyond the last one, lowered by each filler
    assign used_cnt = 2'd3 - 2'(zero3) - 2'(zero4) - 2'(zero5);

    assign b0 = permute_key(i_key);
    assign b1 = {i_entry_id, used_cnt} ^ i_key;
    assign b3 = (zero3 ? FILL_B3 : raw3) ^ i_key;
    assign b4 = (zero4 ? FILL_B4 : raw4) ^ i_key;
    assign b5 = (zero5 ? FILL_B5 : raw5) ^ i_key;
    assign b6 = raw6 ^ i_key;
    assign b2 = b0 + b1 + b3 + b4 + b5 + b6;

    assign o_tx_frame = {b6, b5, b4, b3, b2, b1, b0};

endmodule

>>> rtl/pfc_decode.sv
// ----------------------------------------------------------------------------
// pfc_decode
// Recovers the key from a received frame, unscrambles it and checks it.
// ----------------------------------------------------------------------------
module pfc_decode
    import pfc_pkg::*;
(
    input  t_frame      i_rx_frame,
    output t_dec_result o_result
);

    t_byte                key;
    t_byte                d1, d2, d3, d4, d5, d6;
    t_byte                sum;
    logic                 type_ok;
    logic [VALUE_W-1:0]   value;

    assign key = ~i_rx_frame[7:0];
    assign d1  = i_rx_frame[15:8]  ^ key;
    assign d2  = i_rx_frame[23:16] ^ key;
    assign d3  = i_rx_frame[31:24] ^ key;
    assign d4  = i_rx_frame[39:32] ^ key;
    assign d5  = i_rx_frame[47:40] ^ key;
    assign d6  = i_rx_frame[55:48] ^ key;
    assign sum = key + d1 + d3 + d4 + d5 + d6;

    // Type byte selects how many value bytes are live
    always_comb begin
        type_ok = 1'b1;
        case (d1)
            TYPE_4B: value = {d3, d4, d5, d6};
            TYPE_3B: value = {8'h00, d4, d5, d6};
            TYPE_2B: value = {16'h0000, d5, d6};
            TYPE_1B: value = {24'h000000, d6};
            default: begin
                value   = '0;
                type_ok = 1'b0;
            end
        endcase
    end

    assign o_result.key   = key;
    assign o_result.ok    = type_ok && (sum == d2);
    assign o_result.value = o_result.ok ? value : '0;

endmodule

>>> rtl/param_frame_codec_unit.sv
// ----------------------------------------------------------------------------
// param_frame_codec_unit
// Encode/decode/seed codec for 7-byte parameter storage frames.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the result side is not stalled and returns
// one result transaction for each. Requests are captured in an input register;
// encode and decode are combinational logic between the input register and the
// result register. The key byte is updated as a request moves from the
// input register into the result register, so each request sees the key left
// by the one before it. Input ready drops only while both registers hold
// transactions and the result side is stalled.
module param_frame_codec_unit
    import pfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfc_in_if.sink      i_in,
    pfc_out_if.source   o_out
);

    t_in_item           r_s1, n_s1;
    logic               r_s1_valid;
    t_byte              r_key, n_key;
    logic               r_out_valid;
    t_frame             r_tx_frame, n_tx_frame;
    logic [VALUE_W-1:0] r_read_value, n_read_value;
    logic               r_read_ok, n_read_ok;

    logic               out_free;
    logic               s1_move;
    logic               in_take;
    t_frame             enc_frame;
    t_dec_result        dec_res;

    assign out_free = !r_out_valid || o_out.ready;
    assign s1_move  = r_s1_valid && out_free;
    assign in_take  = i_in.valid && i_in.ready;

    assign i_in.ready = !r_s1_valid || out_free;

    assign n_s1.action      = t_action'(i_in.action);
    assign n_s1.entry_id    = i_in.entry_id;
    assign n_s1.param_value = i_in.param_value;
    assign n_s1.rx_frame    = i_in.rx_frame;

    pfc_encode u_encode (
        .i_key         (r_key),
        .i_entry_id    (r_s1.entry_id),
        .i_param_value (r_s1.param_value),
        .o_tx_frame    (enc_frame)
    );

    pfc_decode u_decode (
        .i_rx_frame (r_s1.rx_frame),
        .o_result   (dec_res)
    );

    always_comb begin
        n_key        = r_key;
        n_tx_frame   = '0;
        n_read_value = '0;
        n_read_ok    = 1'b0;
        case (r_s1.action)
            ACT_ENCODE: n_tx_frame = enc_frame;
            ACT_DECODE: begin
                n_key        = dec_res.key;
                n_read_value = dec_res.value;
                n_read_ok    = dec_res.ok;
            end
            ACT_SEED:   n_key = r_s1.rx_frame[31:24];
            default:    n_key = r_key;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_key       <= '0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_move) begin
                r_key <= n_key;
            end
        end
    end

    // Payload registers: load on handshake, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_tx_frame   <= n_tx_frame;
            r_read_value <= n_read_value;
            r_read_ok    <= n_read_ok;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.tx_frame   = r_tx_frame;
    assign o_out.read_value = r_read_value;
    assign o_out.read_ok    = r_read_ok;

endmodule

>>> rtl/pfc_checker.sv
// ----------------------------------------------------------------------------
// pfc_checker
// Port-level assertions for the parameter frame codec, bound to the top level.
// ----------------------------------------------------------------------------
module pfc_checker
    import pfc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [FRAME_W-1:0]   i_tx_frame,
    input logic [VALUE_W-1:0]   i_read_value,
    input logic                 i_read_ok
);

    // A stalled result transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result transaction dropped while stalled");

    // No result may appear out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // An encoded frame never comes with a successful decode
    a_ok_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_read_ok |-> i_tx_frame == '0)
        else $error("tx frame nonzero with read ok");

    // A failed or absent decode reports zero value
    a_val_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_read_ok |-> i_read_value == '0)
        else $error("read value nonzero without read ok");

    // With an empty pipe, ready must be offered
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(!i_in_valid) && $past(!i_out_valid) && !i_out_valid
        |-> i_in_ready)
        else $error("input not ready with empty pipeline");

endmodule

bind param_frame_codec_unit pfc_checker u_pfc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_tx_frame   (o_out.tx_frame),
    .i_read_value (o_out.read_value),
    .i_read_ok    (o_out.read_ok)
);

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for param_frame_codec_unit. Requests go in through the
// valid/ready request channel, each accepted transaction is run through a
// local codec predictor that tracks the key byte, and every result transaction
// is compared field by field with the oldest expected result. A table of directed
// requests comes first, then random traffic with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb
    import pfc_pkg::*;
();

    localparam int RANDOM_ITEMS       = 1750;
    localparam int LONG_HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER_RESULTS = 400;
    localparam int PAUSE_AT_ITEM      = 1000;
    localparam int DRAIN_CYCLES       = 10;
    localparam int DRAIN_LIMIT        = 5000;
    localparam int TIMEOUT_NS         = 4_000_000;

    // Key bit that feeds frame byte 0 bit i, 3 bits per entry, bit 0 lowest
    localparam logic [23:0] KEY_SCRAMBLE_SRC =
        {3'd2, 3'd4, 3'd0, 3'd6, 3'd1, 3'd7, 3'd3, 3'd5};

    typedef struct packed {
        t_frame      tx_frame;
        logic [31:0] read_value;
        logic        read_ok;
    } t_codec_result;

    typedef struct {
        t_action       action;
        logic [5:0]    entry_id;
        logic [31:0]   param_value;
        t_frame        rx_frame;
        bit            fixed_answer;
        t_codec_result answer;
    } t_codec_req;

    localparam t_codec_result ZERO_RESULT = '0;

    logic clk = 1'b0;
    logic rst_n;

    pfc_in_if  req_ch ();
    pfc_out_if rsp_ch ();

    param_frame_codec_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    always #5 clk = ~clk;

    t_byte         codec_key;
    t_codec_result pending_results [$];
    t_codec_result due;
    int            mismatches   = 0;
    int            results_seen = 0;
    int            sent_count   = 0;
    int            n_encode     = 0;
    int            n_read_ok    = 0;
    int            n_read_bad   = 0;
    int            n_seed       = 0;
    int            n_ignored    = 0;
    bit            hold_done    = 1'b0;
    bit            tx_burst     = 1'b0;
    bit            rx_burst     = 1'b0;

    function automatic t_byte scramble_key(input t_byte k);
        t_byte s;
        for (int i = 0; i < 8; i++) s[i] = k[KEY_SCRAMBLE_SRC[3*i +: 3]];
        return s;
    endfunction

    function automatic t_frame encode_param(input logic [5:0] id, input logic [31:0] value,
                                            input t_byte key);
        t_byte      b [0:6];
        logic [1:0] used;
        b[2] = 8'h00;
        b[3] = value[31:24];
        b[4] = value[23:16];
        b[5] = value[15:8];
        b[6] = value[7:0];
        used = 2'd3;
        // Replace unused upper bytes with their fillers
        if (b[3] == 8'h00) begin
            b[3] = FILL_B3;
            used--;
        end
        if (b[4] == 8'h00) begin
            b[4] = FILL_B4;
            used--;
        end
        if (b[5] == 8'h00) begin
            b[5] = FILL_B5;
            used--;
        end
        b[1] = {id, used};
        for (int k = 1; k < 7; k++) b[k] = b[k] ^ key;
        b[0] = scramble_key(key);
        b[2] = b[0] + b[1] + b[3] + b[4] + b[5] + b[6];
        return {b[6], b[5], b[4], b[3], b[2], b[1], b[0]};
    endfunction

    // Work out the result of one accepted transaction and update the key on a decode or seed
    function automatic t_codec_result predict_codec(input t_codec_req r);
        t_codec_result res;
        t_byte         b [1:6];
        t_byte         sum;
        logic [31:0]   v;
        logic          known;
        res = ZERO_RESULT;
        case (r.action)
            ACT_ENCODE: begin
                res.tx_frame = encode_param(r.entry_id, r.param_value, codec_key);
                n_encode++;
            end
            ACT_DECODE: begin
                codec_key = ~r.rx_frame[7:0];
                for (int k = 1; k < 7; k++) b[k] = r.rx_frame[8*k +: 8] ^ codec_key;
                known = 1'b1;
                case (b[1])
                    TYPE_4B: v = {b[3], b[4], b[5], b[6]};
                    TYPE_3B: v = {8'h00, b[4], b[5], b[6]};
                    TYPE_2B: v = {16'h0000, b[5], b[6]};
                    TYPE_1B: v = {24'h000000, b[6]};
                    default: begin
                        v = '0;
                        known = 1'b0;
                    end
                endcase
                sum = codec_key + b[1] + b[3] + b[4] + b[5] + b[6];
                if (known && sum == b[2]) begin
                    res.read_ok = 1'b1;
                    res.read_value = v;
                    n_read_ok++;
                end else begin
                    n_read_bad++;
                end
            end
            ACT_SEED: begin
                codec_key = r.rx_frame[31:24];
                n_seed++;
            end
            default: n_ignored++;
        endcase
        return res;
    endfunction

    // Received frame that decodes under key with the given type byte and value bytes;
    // a nonzero sum_flip spoils the checksum
    function automatic t_frame build_rx_frame(input t_byte key, input t_byte kind,
                                              input logic [31:0] vb, input t_byte sum_flip);
        t_byte sum;
        sum = key + kind + vb[31:24] + vb[23:16] + vb[15:8] + vb[7:0];
        return {vb[7:0] ^ key, vb[15:8] ^ key, vb[23:16] ^ key, vb[31:24] ^ key,
                (sum ^ sum_flip) ^ key, kind ^ key, ~key};
    endfunction

    function automatic t_frame rand_frame();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[55:0];
    endfunction

    // Random value where each byte is zero a quarter of the time
    function automatic logic [31:0] value_with_gaps();
        logic [31:0] v;
        v = $urandom;
        for (int k = 0; k < 4; k++)
            if ($urandom_range(0, 3) == 0) v[8*k +: 8] = 8'h00;
        return v;
    endfunction

    function automatic t_codec_req mk_req(input t_action a, input logic [5:0] id,
                                          input logic [31:0] v, input t_frame rx,
                                          input bit fixed = 1'b0,
                                          input t_codec_result ans = ZERO_RESULT);
        t_codec_req r;
        r.action       = a;
        r.entry_id     = id;
        r.param_value  = v;
        r.rx_frame     = rx;
        r.fixed_answer = fixed;
        r.answer       = ans;
        return r;
    endfunction

    function automatic t_codec_req random_request();
        t_codec_req r;
        int         pick;
        t_byte      key;
        t_byte      kind;
        pick = $urandom_range(0, 99);
        key  = 8'($urandom);
        case ($urandom_range(0, 9))
            0: key = 8'h00;
            1: key = 8'hFF;
            default: ;
        endcase
        case ($urandom_range(0, 3))
            0: kind = TYPE_4B;
            1: kind = TYPE_3B;
            2: kind = TYPE_2B;
            default: kind = TYPE_1B;
        endcase
        r = mk_req(ACT_DECODE, 6'($urandom), value_with_gaps(), rand_frame());
        if (pick < 35) begin
            r.action = ACT_ENCODE;
        end else if (pick < 65) begin
            r.rx_frame = build_rx_frame(key, kind, value_with_gaps(), 8'h00);
        end else if (pick < 75) begin
            r.rx_frame = build_rx_frame(key, kind, value_with_gaps(),
                                        8'($urandom_range(1, 255)));
        end else if (pick < 80) begin
            kind = 8'($urandom);
            if (kind == TYPE_4B || kind == TYPE_3B || kind == TYPE_2B || kind == TYPE_1B)
                kind = kind ^ 8'h01;
            r.rx_frame = build_rx_frame(key, kind, value_with_gaps(), 8'h00);
        end else if (pick < 87) begin
            // raw noise frame, left as drawn
        end else if (pick < 96) begin
            r.action = ACT_SEED;
        end else begin
            r.action = ACT_NONE;
        end
        return r;
    endfunction

    task automatic send_request(input t_codec_req r);
        int            gap;
        t_codec_result want;
        if (sent_count % 64 == 0) tx_burst = ($urandom_range(0, 3) == 0);
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.action      <= r.action;
        req_ch.entry_id    <= r.entry_id;
        req_ch.param_value <= r.param_value;
        req_ch.rx_frame    <= r.rx_frame;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        want = predict_codec(r);
        pending_results.push_back(r.fixed_answer ? r.answer : want);
        sent_count++;
    endtask

    function automatic void check_field(input string name, input logic [55:0] want,
                                        input logic [55:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending: expected none, got tx=%h val=%h ok=%b",
                         $time, rsp_ch.tx_frame, rsp_ch.read_value, rsp_ch.read_ok);
                mismatches++;
            end else begin
                due = pending_results.pop_front();
                check_field("tx_frame", due.tx_frame, rsp_ch.tx_frame);
                check_field("read_value", 56'(due.read_value), 56'(rsp_ch.read_value));
                check_field("read_ok", 56'(due.read_ok), 56'(rsp_ch.read_ok));
            end
        end
    end

    // Result side: random stalls, one long hold-off to back up the pipe
    initial begin
        int stall;
        int taken;
        taken = 0;
        rsp_ch.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (!hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            if (taken % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            stall = rx_burst ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            taken++;
        end
    end

    initial begin
        t_codec_req dir_rows [$];
        t_codec_req req;
        int         issued;
        int         drain_wait;
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.action      <= ACT_NONE;
        req_ch.entry_id    <= '0;
        req_ch.param_value <= '0;
        req_ch.rx_frame    <= '0;
        codec_key = 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Key is zero after reset, so the first two encodes can be read off directly
        dir_rows.push_back(mk_req(ACT_ENCODE, 6'h00, 32'h0000_0000, '0,
                                  1'b1, '{56'h00999669980000, 32'h0, 1'b0}));
        dir_rows.push_back(mk_req(ACT_ENCODE, 6'h3F, 32'hFFFF_FFFF, '1,
                                  1'b1, '{56'hFFFFFFFFFBFF00, 32'h0, 1'b0}));
        dir_rows.push_back(mk_req(ACT_NONE, 6'h3F, 32'hDEAD_BEEF, '1, 1'b1, ZERO_RESULT));
        dir_rows.push_back(mk_req(ACT_ENCODE, 6'h15, 32'h0000_0001, '0));
        dir_rows.push_back(mk_req(ACT_ENCODE, 6'h2A, 32'h0100_0000, '0));
        dir_rows.push_back(mk_req(ACT_ENCODE, 6'h01, 32'h0001_0000, '0));
        dir_rows.push_back(mk_req(ACT_ENCODE, 6'h20, 32'h0000_0100, '0));
        dir_rows.push_back(mk_req(ACT_ENCODE, 6'h0C, 32'h1234_5678, '0));
        dir_rows.push_back(mk_req(ACT_SEED, 6'h00, 32'h0, 56'h000000FF000000,
                                  1'b1, ZERO_RESULT));
        dir_rows.push_back(mk_req(ACT_ENCODE, 6'h00, 32'h0000_0000, '0));
        dir_rows.push_back(mk_req(ACT_ENCODE, 6'h3F, 32'hFFFF_FFFF, '0));
        // Decodes, the first two with an unknown type byte
        dir_rows.push_back(mk_req(ACT_DECODE, 6'h00, 32'h0, '0, 1'b1, ZERO_RESULT));
        dir_rows.push_back(mk_req(ACT_DECODE, 6'h00, 32'h0, '1, 1'b1, ZERO_RESULT));
        dir_rows.push_back(mk_req(ACT_DECODE, 6'h05, 32'h0,
                                  build_rx_frame(8'h00, TYPE_4B, 32'h8142_24FF, 8'h00)));
        dir_rows.push_back(mk_req(ACT_DECODE, 6'h0A, 32'h0,
                                  build_rx_frame(8'hFF, TYPE_3B, 32'h00FE_0180, 8'h00)));
        dir_rows.push_back(mk_req(ACT_DECODE, 6'h14, 32'h0,
                                  build_rx_frame(8'h3C, TYPE_2B, 32'h7700_C3A5, 8'h00)));
        dir_rows.push_back(mk_req(ACT_DECODE, 6'h28, 32'h0,
                                  build_rx_frame(8'hC3, TYPE_1B, 32'hFFFF_FF01, 8'h00)));
        dir_rows.push_back(mk_req(ACT_DECODE, 6'h00, 32'h0,
                                  build_rx_frame(8'h81, TYPE_3B, 32'h0012_3456, 8'h01),
                                  1'b1, ZERO_RESULT));
        dir_rows.push_back(mk_req(ACT_DECODE, 6'h00, 32'h0,
                                  build_rx_frame(8'h5A, 8'h00, 32'h1122_3344, 8'h00),
                                  1'b1, ZERO_RESULT));
        dir_rows.push_back(mk_req(ACT_DECODE, 6'h00, 32'h0,
                                  build_rx_frame(8'h66, TYPE_4B, 32'h0000_0000, 8'h00)));
        dir_rows.push_back(mk_req(ACT_SEED, 6'h00, 32'h0, 56'hFFFFFF00FFFFFF,
                                  1'b1, ZERO_RESULT));
        dir_rows.push_back(mk_req(ACT_ENCODE, 6'h33, 32'h89AB_CDEF, '0));
        dir_rows.push_back(mk_req(ACT_NONE, 6'h00, 32'h0, 56'h123456789ABCDE,
                                  1'b1, ZERO_RESULT));
        dir_rows.push_back(mk_req(ACT_ENCODE, 6'h1E, 32'h0000_00A5, '0));

        foreach (dir_rows[i]) send_request(dir_rows[i]);

        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            // Hold the request side once until the codec has fully drained
            if (issued == PAUSE_AT_ITEM && pending_results.size() != 0) begin
                req_ch.valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge clk);
            end
            req = random_request();
            send_request(req);
            issued++;
        end
        req_ch.valid <= 1'b0;

        drain_wait = 0;
        while (pending_results.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            mismatches += pending_results.size();
        end

        $display("Ran %0d encodes, %0d good and %0d rejected decodes, %0d key loads, %0d no-ops",
                 n_encode, n_read_ok, n_read_bad, n_seed, n_ignored);
        $display("Compared %0d results, %0d field mismatches", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: run timed out with %0d results pending", $time, pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
